// File: sv/dnw_pkg.sv
// ----------------------------------------------------------------------------
// dnw_pkg
// Shared types, constants and the delimiter decode for the DNS name to wire
// format converter.
// ----------------------------------------------------------------------------
package dnw_pkg;

  // Wire buffer size in bytes; positions run up to and including this value.
  parameter int unsigned WireBufBytes = 256;
  parameter int unsigned MaxLabelLen  = 63;
  parameter int unsigned PosW         = $clog2(WireBufBytes + 1);

  // Result queue; depth must be a power of two.
  parameter int unsigned QueueDepth   = 4;
  parameter int unsigned QPtrW        = $clog2(QueueDepth);
  parameter int unsigned QCntW        = $clog2(QueueDepth + 1);

  parameter logic [7:0] CharNul    = 8'h00;
  parameter logic [7:0] CharTab    = 8'h09;
  parameter logic [7:0] CharLf     = 8'h0a;
  parameter logic [7:0] CharCr     = 8'h0d;
  parameter logic [7:0] CharSpace  = 8'h20;
  parameter logic [7:0] CharQuote  = 8'h22;
  parameter logic [7:0] CharLParen = 8'h28;
  parameter logic [7:0] CharRParen = 8'h29;
  parameter logic [7:0] CharSemi   = 8'h3b;
  parameter logic [7:0] CharDot    = 8'h2e;

  typedef struct packed {
    logic [PosW-1:0] label_slot;
    logic [PosW-1:0] write_position;
    logic [7:0]      chars_taken;
    logic            overflowed;
  } conv_state_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_offset;
    logic [7:0] write_data;
    logic       name_done;
    logic       name_failed;
    logic [7:0] consumed_count;
  } wire_res_t;

  function automatic logic is_delim(input logic [7:0] c);
    logic hit;
    begin
      hit = c inside {CharNul, CharTab, CharLf, CharCr, CharSpace, CharQuote,
                      CharLParen, CharRParen, CharSemi, CharDot};
      return hit;
    end
  endfunction

  function automatic conv_state_t state_init();
    conv_state_t s;
    begin
      s.label_slot     = '0;
      s.write_position = PosW'(1);
      s.chars_taken    = '0;
      s.overflowed     = 1'b0;
      return s;
    end
  endfunction

endpackage

// File: sv/dns_name_to_wire.sv
// ----------------------------------------------------------------------------
// dns_name_to_wire
// Converts a dotted domain name, one character per item, into DNS wire format
// buffer writes (offset, byte), with done/failed status per name.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  char_byte_i
//  out      output     out_valid_o/out_ready_i write_*, name_done_o,
//                                              name_failed_o, consumed_count_o
//
// One character is taken per cycle while the queue has room for two results; a
// name-ending delimiter that completes a name makes two results, which the output
// drains at one per cycle while out_ready_i is high. A result passes the input
// register, then a four-entry result queue, before it is offered.
// Reset returns the converter to the start of a name with an empty queue.
// A stalled output fills the queue, and the input register then holds.
// ----------------------------------------------------------------------------
module dns_name_to_wire (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       write_valid_o,
  output logic [7:0] write_offset_o,
  output logic [7:0] write_data_o,
  output logic       name_done_o,
  output logic       name_failed_o,
  output logic [7:0] consumed_count_o
);
  import dnw_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_char_q;
  conv_state_t st_q, st_d, st_next;
  wire_res_t   res0, res1, out_res;
  logic [1:0]  res_cnt;
  logic        room2;
  logic        fire;

  assign fire       = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || fire;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    st_d = fire ? st_next : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= state_init();
    end else begin
      in_vld_q <= in_vld_d;
      st_q     <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_char_q <= char_byte_i;
    end
  end

  dnw_step u_step (
    .char_i    (in_char_q),
    .state_i   (st_q),
    .state_o   (st_next),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  dnw_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (fire ? res_cnt : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign write_valid_o    = out_res.write_valid;
  assign write_offset_o   = out_res.write_offset;
  assign write_data_o     = out_res.write_data;
  assign name_done_o      = out_res.name_done;
  assign name_failed_o    = out_res.name_failed;
  assign consumed_count_o = out_res.consumed_count;

endmodule

// File: sv/dnw_step.sv
// ----------------------------------------------------------------------------
// dnw_step
// Per-character conversion step: classifies the character, computes the
// label length and gives the next state and up to two buffer writes.
// ----------------------------------------------------------------------------
module dnw_step (
  input  logic [7:0]          char_i,
  input  dnw_pkg::conv_state_t state_i,
  output dnw_pkg::conv_state_t state_o,
  output dnw_pkg::wire_res_t  res0_o,
  output dnw_pkg::wire_res_t  res1_o,
  output logic [1:0]          res_cnt_o
);
  import dnw_pkg::*;

  logic            delim;
  logic            dot;
  logic            full;
  logic            fail;
  logic [PosW-1:0] len;

  assign delim = is_delim(char_i);
  assign dot   = (char_i == CharDot);
  assign full  = (state_i.write_position >= PosW'(WireBufBytes));
  assign len   = (state_i.write_position > state_i.label_slot)
               ? state_i.write_position - state_i.label_slot - PosW'(1)
               : '0;
  assign fail  = state_i.overflowed || (len == '0) || (len > PosW'(MaxLabelLen))
               || (!dot && full);

  always_comb begin
    state_o   = state_i;
    res0_o    = '0;
    res1_o    = '0;
    res_cnt_o = 2'd0;
    if (!delim) begin
      if (full) begin
        // drop the character, remember the overflow for the delimiter
        state_o.overflowed = 1'b1;
      end else begin
        res0_o.write_valid     = 1'b1;
        res0_o.write_offset    = state_i.write_position[7:0];
        res0_o.write_data      = char_i;
        res_cnt_o              = 2'd1;
        state_o.write_position = state_i.write_position + PosW'(1);
        state_o.chars_taken    = state_i.chars_taken + 8'd1;
      end
    end else if (fail) begin
      res0_o.name_done   = 1'b1;
      res0_o.name_failed = 1'b1;
      res_cnt_o          = 2'd1;
      state_o            = state_init();
    end else begin
      // fill the length slot kept free at the label start
      res0_o.write_valid  = 1'b1;
      res0_o.write_offset = state_i.label_slot[7:0];
      res0_o.write_data   = len[7:0];
      if (dot) begin
        res_cnt_o           = 2'd1;
        state_o.chars_taken = state_i.chars_taken + 8'd1;
        state_o.label_slot  = state_i.write_position;
        if (full) begin
          state_o.overflowed = 1'b1;
        end else begin
          state_o.write_position = state_i.write_position + PosW'(1);
        end
      end else begin
        res_cnt_o             = 2'd2;
        res1_o.write_valid    = 1'b1;
        res1_o.write_offset   = state_i.write_position[7:0];
        res1_o.write_data     = 8'd0;
        res1_o.name_done      = 1'b1;
        res1_o.consumed_count = state_i.chars_taken;
        state_o               = state_init();
      end
    end
  end

endmodule

// File: sv/dnw_res_queue.sv
// ----------------------------------------------------------------------------
// dnw_res_queue
// Small result queue: takes up to two results per cycle, gives one per cycle
// on a valid/ready output.
// ----------------------------------------------------------------------------
module dnw_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_cnt_i,
  input  dnw_pkg::wire_res_t push0_i,
  input  dnw_pkg::wire_res_t push1_i,
  output logic               room2_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dnw_pkg::wire_res_t out_o
);
  import dnw_pkg::*;

  wire_res_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign room2_o     = (cnt_q <= QCntW'(QueueDepth - 2));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    // pointers wrap on their own since the depth is a power of two
    wr_ptr_d = wr_ptr_q + QPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    cnt_d    = cnt_q + QCntW'(push_cnt_i) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("result queue count past depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room2_o)
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[QPtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// File: tb/dnw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnw_checker
// Watches both channels of the name-to-wire converter, predicts the buffer
// writes and done/failed status for every accepted character, and compares
// each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dnw_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       write_valid_i,
  input  logic [7:0] write_offset_i,
  input  logic [7:0] write_data_i,
  input  logic       name_done_i,
  input  logic       name_failed_i,
  input  logic [7:0] consumed_count_i,
  output int         fail_cnt_o,
  output int         pending_o
);
  import dnw_pkg::*;

  // Converter state as this side sees it
  int unsigned slot_pos;
  int unsigned next_pos;
  int unsigned taken;
  bit          ovf;
  int          fails;

  wire_res_t   wire_q[$];

  function automatic bit is_sep(input logic [7:0] c);
    case (c)
      CharNul, CharTab, CharLf, CharCr, CharSpace, CharQuote,
      CharLParen, CharRParen, CharSemi, CharDot: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic wire_res_t make_res(input bit v, input int unsigned off,
                                         input int unsigned data, input bit done,
                                         input bit failed, input int unsigned cnt);
    wire_res_t r;
    r.write_valid    = v;
    r.write_offset   = 8'(off);
    r.write_data     = 8'(data);
    r.name_done      = done;
    r.name_failed    = failed;
    r.consumed_count = 8'(cnt);
    return r;
  endfunction

  task automatic start_name();
    slot_pos = 0;
    next_pos = 1;
    taken    = 0;
    ovf      = 1'b0;
  endtask

  task automatic encode_char(input logic [7:0] c);
    int unsigned len;
    bit          dot;
    if (!is_sep(c)) begin
      // Full buffer: drop the character, no result
      if (next_pos >= WireBufBytes) begin
        ovf = 1'b1;
      end else begin
        wire_q.push_back(make_res(1'b1, next_pos, c, 1'b0, 1'b0, 0));
        next_pos++;
        taken++;
      end
    end else begin
      dot = (c == CharDot);
      len = (next_pos > slot_pos) ? next_pos - slot_pos - 1 : 0;
      if (ovf || len == 0 || len > MaxLabelLen || (!dot && next_pos >= WireBufBytes)) begin
        wire_q.push_back(make_res(1'b0, 0, 0, 1'b1, 1'b1, 0));
        start_name();
      end else begin
        wire_q.push_back(make_res(1'b1, slot_pos, len, 1'b0, 1'b0, 0));
        if (dot) begin
          taken++;
          slot_pos = next_pos;
          if (next_pos >= WireBufBytes) ovf = 1'b1;
          else next_pos++;
        end else begin
          wire_q.push_back(make_res(1'b1, next_pos, 0, 1'b1, 1'b0, taken));
          start_name();
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wire_res_t want;
    if (!rst_ni) begin
      start_name();
      wire_q.delete();
      fails = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (wire_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got offset %0h data %0h",
                   $time, write_offset_i, write_data_i);
          fails++;
        end else begin
          want = wire_q.pop_front();
          check_field("write_valid", 8'(want.write_valid), 8'(write_valid_i));
          check_field("write_offset", want.write_offset, write_offset_i);
          check_field("write_data", want.write_data, write_data_i);
          check_field("name_done", 8'(want.name_done), 8'(name_done_i));
          check_field("name_failed", 8'(want.name_failed), 8'(name_failed_i));
          check_field("consumed_count", want.consumed_count, consumed_count_i);
        end
      end
      if (in_valid_i && in_ready_i) encode_char(char_byte_i);
      pending_o  <= wire_q.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the name-to-wire converter with directed names and then random
// well-formed names, oversized labels, buffer-filling names and noise,
// under bursty input and a stalling output, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import dnw_pkg::*;

  localparam int ItemTarget  = 1250;
  localparam int CycleLimit  = 200000;
  localparam int HoldStart   = 500;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;
  localparam int NumDirected = 28;

  localparam logic [7:0] Directed [NumDirected] = '{
    8'h80, CharDot, 8'hff, CharNul,
    8'h01, CharTab,
    8'h78, CharLf, 8'h79, CharCr, 8'h7a, CharSpace, 8'h71, CharQuote,
    8'h72, CharLParen, 8'h73, CharRParen, 8'h74, CharSemi,
    CharDot,
    8'h6d, CharDot, CharSemi,
    CharNul,
    8'h6b, CharDot, CharDot
  };

  logic [7:0] name_ends [9] = '{CharNul, CharTab, CharLf, CharCr, CharSpace,
                                CharQuote, CharLParen, CharRParen, CharSemi};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] char_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       write_valid_o;
  logic [7:0] write_offset_o;
  logic [7:0] write_data_o;
  logic       name_done_o;
  logic       name_failed_o;
  logic [7:0] consumed_count_o;

  int fail_cnt;
  int pending;
  int cycle_cnt  = 0;
  int items_sent = 0;
  int burst_left = 0;
  int names_cnt  = 0;
  int big_cnt    = 0;

  dns_name_to_wire DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_byte_i     (char_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_valid_o   (write_valid_o),
    .write_offset_o  (write_offset_o),
    .write_data_o    (write_data_o),
    .name_done_o     (name_done_o),
    .name_failed_o   (name_failed_o),
    .consumed_count_o(consumed_count_o)
  );

  dnw_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .char_byte_i     (char_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_valid_i   (write_valid_o),
    .write_offset_i  (write_offset_o),
    .write_data_i    (write_data_o),
    .name_done_i     (name_done_o),
    .name_failed_i   (name_failed_o),
    .consumed_count_i(consumed_count_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item; idle between bursts, then hold until accepted
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    bit         hit;
    do begin
      c   = 8'($urandom_range(0, 255));
      hit = (c == CharDot);
      foreach (name_ends[i]) if (c == name_ends[i]) hit = 1'b1;
    end while (hit);
    return c;
  endfunction

  task automatic send_label(input int len);
    repeat (len) send_char(label_char());
  endtask

  task automatic send_name();
    int pat;
    int nlab;
    int len;
    int r;
    names_cnt++;
    if (names_cnt % 12 == 5) begin
      // Names that reach the end of the buffer
      pat  = big_cnt % 4;
      big_cnt++;
      nlab = (pat == 3) ? 6 : 4;
      for (int i = 0; i < nlab; i++) begin
        if (pat == 3) len = $urandom_range(40, 63);
        else if (pat == 0 && i == 3) len = 62;
        else len = 63;
        send_label(len);
        if (i < nlab - 1) send_char(CharDot);
      end
      if (pat == 2) begin
        send_char(CharDot);
        send_label(1);
      end
      send_char(name_ends[$urandom_range(0, 8)]);
    end else if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
    end else begin
      nlab = $urandom_range(1, 5);
      for (int i = 0; i < nlab; i++) begin
        r = $urandom_range(0, 29);
        if (r == 0) len = 0;
        else if (r == 1) len = MaxLabelLen;
        else if (r == 2) len = MaxLabelLen + 1;
        else len = $urandom_range(1, 12);
        send_label(len);
        if (i < nlab - 1) send_char(CharDot);
      end
      if ($urandom_range(0, 9) == 0) send_char(CharDot);
      send_char(name_ends[$urandom_range(0, 8)]);
    end
  endtask

  // Output side: random stall patterns, plus one long hold-off
  initial begin
    int mode;
    int run;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 120);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (cycle_cnt % 3 != 0);
        endcase
      end
      if (!held && cycle_cnt >= HoldStart) begin
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held = 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (Directed[i]) send_char(Directed[i]);
    while (items_sent < ItemTarget) send_name();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
